// ===== rtl/assert_macros.svh =====
// assertion macros for the grid path counter
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset: disabled while rst is low
`define GAPC_ASSERT(lbl, clk, rst, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// check that also holds during reset
`define GAPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gapc_pkg.sv =====
// shared types and constants for the grid path counter
// no dependencies; used by the interfaces and the top level
`default_nettype none

package gapc_pkg;

    localparam int HEIGHT_W      = 4;
    localparam int COUNT_W       = 19;
    localparam int TOTAL_W       = 32;
    localparam int CFG_W         = 7;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int MAX_ROWS_DEF  = 64;

    localparam logic [HEIGHT_W-1:0] TOP_HEIGHT  = 4'd9;
    localparam logic [HEIGHT_W-1:0] BASE_HEIGHT = 4'd0;
    localparam logic [HEIGHT_W-1:0] WALL        = 4'd15;
    localparam logic [CFG_W-1:0]    CFG_RESET   = 7'd64;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_GRID_WIDTH = 1'b0,
        REG_GRID_ROWS  = 1'b1
    } reg_idx_t;

    // one grid position in the scratch memory
    typedef struct packed {
        logic [HEIGHT_W-1:0] hgt;
        logic [COUNT_W-1:0]  cnt;
    } ram_word_t;

endpackage

`default_nettype wire

// ===== rtl/gapc_in_if.sv =====
// cell request channel: valid/ready plus one grid cell
// depends on gapc_pkg
`default_nettype none

interface gapc_in_if
    import gapc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;
    logic                last_cell;

    modport source (output valid, height, last_cell, input ready);
    modport sink   (input valid, height, last_cell, output ready);
endinterface

`default_nettype wire

// ===== rtl/gapc_out_if.sv =====
// result request channel: valid/ready plus path total
// depends on gapc_pkg
`default_nettype none

interface gapc_out_if
    import gapc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_paths;
    logic               saturated;

    modport source (output valid, total_paths, saturated, input ready);
    modport sink   (input valid, total_paths, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/grid_ascending_path_counter.sv =====
// top level of the grid path counter: apb registers, sequencer, scratch ram
// depends on gapc_pkg, gapc_in_if, gapc_out_if, gapc_ram, assert_macros.svh
// Loads a height grid in row-major order, one cell request per idle cycle, into a scratch ram.
// The request flagged last_cell starts the count of all paths that begin on a height-0
// cell, step north/south/east/west inside the grid, rise by exactly one per step and end
// on height 9; heights 10 to 15, and positions not loaded in the current grid, block.
// Grid size comes from grid_width (0x0) and grid_rows (0x4), each clamped to
// 1..MAX_WIDTH / 1..MAX_ROWS; cells past width*rows are dropped. The last cell keeps the
// block busy through init, 9 layers that walk every position and read the neighbors of
// each cell of the layer's height, final summing, and posting the result. All of this is
// set by the single read port of the scratch ram, walked one position per step, and by
// the one shared adder. One result comes back per last cell: total_paths with a
// saturated flag; a later grid loads while that result waits to be taken.
`default_nettype none
`include "assert_macros.svh"

module grid_ascending_path_counter
    import gapc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    gapc_in_if.sink                    item_in,
    gapc_out_if.source                 result_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int RWS_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ACC_W  = TOTAL_W + 1;

    // sequencer states
    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_INIT_RD = 11'b000_0000_0010,
        S_INIT_WR = 11'b000_0000_0100,
        S_OWN_RD  = 11'b000_0000_1000,
        S_OWN_CHK = 11'b000_0001_0000,
        S_NB_RD   = 11'b000_0010_0000,
        S_NB_ACC  = 11'b000_0100_0000,
        S_CELL_WR = 11'b000_1000_0000,
        S_SUM_RD  = 11'b001_0000_0000,
        S_SUM_ACC = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

    // neighbor visited in the current step
    typedef enum logic [1:0] {
        DIR_NORTH,
        DIR_SOUTH,
        DIR_EAST,
        DIR_WEST
    } dir_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    gw_reg, gr_reg;
    logic [CNT_W-1:0]    load_idx_reg, load_idx_next;
    logic [WID_W-1:0]    w_run_reg, w_run_next;
    logic [RWS_W-1:0]    r_run_reg, r_run_next;
    logic [CNT_W-1:0]    cells_run_reg, cells_run_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    dir_t                dir_reg, dir_next;
    logic [ADDR_W-1:0]   nb_pos_reg, nb_pos_next;
    logic [HEIGHT_W-1:0] layer_reg, layer_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                sat_reg, sat_next;

    // grid size in force right now
    logic [WID_W-1:0]    w_cur;
    logic [RWS_W-1:0]    r_cur;
    logic [CNT_W-1:0]    cells_cur;

    // ram port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    ram_word_t           ram_wdata, rd_word;
    logic [$bits(ram_word_t)-1:0] ram_rdata;

    // walk helpers
    logic                last_pos_c, col_last_c;
    logic [ADDR_W-1:0]   pos_step_c;
    logic [COL_W-1:0]    col_step_c;
    logic [ROW_W-1:0]    row_step_c;
    logic                nb_ok_c;
    logic [ADDR_W-1:0]   nb_addr_c;
    logic [HEIGHT_W-1:0] own_h_c, nb_h_c, cur_c;
    logic [ACC_W-1:0]    sum_c;
    logic                cfg_wr;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= CFG_RESET;
            gr_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_GRID_WIDTH: gw_reg <= pwdata[CFG_W-1:0];
                REG_GRID_ROWS:  gr_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_GRID_WIDTH: prdata = APB_DATA_W'(gw_reg);
            REG_GRID_ROWS:  prdata = APB_DATA_W'(gr_reg);
        endcase
    end

    // clamp both sizes into 1..max
    always_comb
    begin
        if (gw_reg == '0)
            w_cur = WID_W'(1);
        else if (int'(gw_reg) > MAX_WIDTH)
            w_cur = WID_W'(MAX_WIDTH);
        else
            w_cur = WID_W'(gw_reg);

        if (gr_reg == '0)
            r_cur = RWS_W'(1);
        else if (int'(gr_reg) > MAX_ROWS)
            r_cur = RWS_W'(MAX_ROWS);
        else
            r_cur = RWS_W'(gr_reg);

        cells_cur = CNT_W'(w_cur) * CNT_W'(r_cur);
    end

    // ---------------------------------------------------------------
    // scratch ram: height and path count per position
    // ---------------------------------------------------------------
    gapc_ram #(
        .WIDTH ($bits(ram_word_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_word = ram_word_t'(ram_rdata);

    // ---------------------------------------------------------------
    // walk and neighbor addressing
    // ---------------------------------------------------------------
    assign last_pos_c = ((CNT_W'(pos_reg) + CNT_W'(1)) == cells_run_reg);
    assign col_last_c = ((WID_W'(col_reg) + WID_W'(1)) == w_run_reg);
    assign pos_step_c = last_pos_c ? '0 : pos_reg + ADDR_W'(1);
    assign col_step_c = (last_pos_c || col_last_c) ? '0 : col_reg + COL_W'(1);
    assign row_step_c = last_pos_c ? '0 : (col_last_c ? row_reg + ROW_W'(1) : row_reg);

    always_comb
    begin
        unique case (dir_reg)
            DIR_NORTH:
            begin
                nb_ok_c   = (row_reg != '0);
                nb_addr_c = ADDR_W'(CNT_W'(pos_reg) - CNT_W'(w_run_reg));
            end
            DIR_SOUTH:
            begin
                nb_ok_c   = ((RWS_W'(row_reg) + RWS_W'(1)) < r_run_reg);
                nb_addr_c = ADDR_W'(CNT_W'(pos_reg) + CNT_W'(w_run_reg));
            end
            DIR_EAST:
            begin
                nb_ok_c   = ((WID_W'(col_reg) + WID_W'(1)) < w_run_reg);
                nb_addr_c = pos_reg + ADDR_W'(1);
            end
            DIR_WEST:
            begin
                nb_ok_c   = (col_reg != '0);
                nb_addr_c = pos_reg - ADDR_W'(1);
            end
        endcase
    end

    // positions not loaded in this grid read as walls
    assign own_h_c = (CNT_W'(pos_reg) >= load_idx_reg) ? WALL : rd_word.hgt;
    assign nb_h_c  = (CNT_W'(nb_pos_reg) >= load_idx_reg) ? WALL : rd_word.hgt;
    assign cur_c   = layer_reg - HEIGHT_W'(1);

    // the one shared adder: neighbor sums and the final total
    assign sum_c = acc_reg + ACC_W'(rd_word.cnt);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        load_idx_next  = load_idx_reg;
        w_run_next     = w_run_reg;
        r_run_next     = r_run_reg;
        cells_run_next = cells_run_reg;
        pos_next       = pos_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        dir_next       = dir_reg;
        nb_pos_next    = nb_pos_reg;
        layer_next     = layer_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        total_next     = total_reg;
        sat_next       = sat_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = '0;
        ram_raddr      = pos_reg;

        // result taken downstream
        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    // store the cell if it fits the current grid size
                    if (load_idx_reg < cells_cur)
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = load_idx_reg[ADDR_W-1:0];
                        ram_wdata.hgt = item_in.height;
                        load_idx_next = load_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        load_idx_next = cells_cur;
                    end
                    if (item_in.last_cell)
                    begin
                        w_run_next     = w_cur;
                        r_run_next     = r_cur;
                        cells_run_next = cells_cur;
                        pos_next       = '0;
                        col_next       = '0;
                        row_next       = '0;
                        state_next     = S_INIT_RD;
                    end
                end
            end

            S_INIT_RD:
            begin
                state_next = S_INIT_WR;
            end

            // seed: every height-9 cell ends exactly one path
            S_INIT_WR:
            begin
                ram_we        = 1'b1;
                ram_wdata.hgt = rd_word.hgt;
                ram_wdata.cnt = (own_h_c == TOP_HEIGHT) ? COUNT_W'(1) : '0;
                pos_next      = pos_step_c;
                col_next      = col_step_c;
                row_next      = row_step_c;
                if (last_pos_c)
                begin
                    layer_next = TOP_HEIGHT;
                    state_next = S_OWN_RD;
                end
                else
                begin
                    state_next = S_INIT_RD;
                end
            end

            S_OWN_RD:
            begin
                state_next = S_OWN_CHK;
            end

            S_OWN_CHK:
            begin
                if (own_h_c == cur_c)
                begin
                    acc_next   = '0;
                    dir_next   = DIR_NORTH;
                    state_next = S_NB_RD;
                end
                else
                begin
                    pos_next = pos_step_c;
                    col_next = col_step_c;
                    row_next = row_step_c;
                    if (!last_pos_c)
                        state_next = S_OWN_RD;
                    else if (layer_reg == BASE_HEIGHT + HEIGHT_W'(1))
                    begin
                        acc_next   = '0;
                        state_next = S_SUM_RD;
                    end
                    else
                    begin
                        layer_next = cur_c;
                        state_next = S_OWN_RD;
                    end
                end
            end

            // off-grid neighbors are skipped without a read
            S_NB_RD:
            begin
                if (nb_ok_c)
                begin
                    ram_raddr   = nb_addr_c;
                    nb_pos_next = nb_addr_c;
                    state_next  = S_NB_ACC;
                end
                else if (dir_reg == DIR_WEST)
                    state_next = S_CELL_WR;
                else
                    dir_next = dir_t'(dir_reg + 2'd1);
            end

            S_NB_ACC:
            begin
                if (nb_h_c == layer_reg)
                begin
                    acc_next = sum_c;
                end
                if (dir_reg == DIR_WEST)
                    state_next = S_CELL_WR;
                else
                begin
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = S_NB_RD;
                end
            end

            S_CELL_WR:
            begin
                ram_we        = 1'b1;
                ram_wdata.hgt = cur_c;
                ram_wdata.cnt = acc_reg[COUNT_W-1:0];
                pos_next      = pos_step_c;
                col_next      = col_step_c;
                row_next      = row_step_c;
                if (!last_pos_c)
                    state_next = S_OWN_RD;
                else if (layer_reg == BASE_HEIGHT + HEIGHT_W'(1))
                begin
                    acc_next   = '0;
                    state_next = S_SUM_RD;
                end
                else
                begin
                    layer_next = cur_c;
                    state_next = S_OWN_RD;
                end
            end

            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end

            // add up the counts of all heads
            S_SUM_ACC:
            begin
                if (own_h_c == BASE_HEIGHT)
                begin
                    acc_next = sum_c;
                end
                pos_next = pos_step_c;
                col_next = col_step_c;
                row_next = row_step_c;
                state_next = last_pos_c ? S_DONE : S_SUM_RD;
            end

            // post once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    sat_next       = acc_reg[TOTAL_W];
                    total_next     = acc_reg[TOTAL_W] ? '1 : acc_reg[TOTAL_W-1:0];
                    load_idx_next  = '0;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            dir_reg       <= DIR_NORTH;
            layer_reg     <= TOP_HEIGHT;
            cells_run_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            load_idx_reg  <= load_idx_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            dir_reg       <= dir_next;
            layer_reg     <= layer_next;
            cells_run_reg <= cells_run_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        w_run_reg  <= w_run_next;
        r_run_reg  <= r_run_next;
        nb_pos_reg <= nb_pos_next;
        acc_reg    <= acc_next;
        total_reg  <= total_next;
        sat_reg    <= sat_next;
    end

    assign item_in.ready          = (state_reg == S_IDLE);
    assign result_out.valid       = out_valid_reg;
    assign result_out.total_paths = total_reg;
    assign result_out.saturated   = sat_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `GAPC_ASSERT(a_load_idx_in_grid, clk, rst_n,
        (state_reg != S_IDLE) |-> (load_idx_reg <= cells_run_reg),
        "load index beyond grid during count")
    `GAPC_ASSERT(a_result_from_done, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE),
        "result posted outside the done step")
    `GAPC_ASSERT(a_nb_after_read, clk, rst_n,
        (state_reg == S_NB_ACC) |-> $past(state_reg == S_NB_RD),
        "neighbor accumulate without a neighbor read")

endmodule

`default_nettype wire

// ===== rtl/gapc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module gapc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
